/* design/sbda_pkg.sv */
// Shared constants and helpers for the signed binary to decimal ASCII unit.
package sbda_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 64;
    localparam int VALUE_PORT_W        = 64;
    localparam int CHAR_W              = 8;
    localparam int QUEUE_DEPTH         = 2;
    localparam int BITS_PER_STEP       = 4;

    localparam logic [CHAR_W-1:0] MINUS_CODE = 8'h2D;
    localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'h30;

    localparam logic [3:0] BCD_ADJUST_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJUST       = 4'd3;

    // Decimal digits needed for any magnitude of w bits: floor(w * log10(2)) + 1.
    function automatic int digit_count(input int w);
        return (w * 30103) / 100000 + 1;
    endfunction

endpackage

/* design/sbda_front.sv */
// Front end: takes a request, splits sign and magnitude, converts the magnitude to BCD.
module sbda_front #(
    parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEFAULT,
    parameter int NUM_DIGITS  = sbda_pkg::digit_count(VALUE_WIDTH),
    parameter int IDX_W       = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1,
    parameter int ENTRY_W     = 1 + IDX_W + NUM_DIGITS * 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [sbda_pkg::VALUE_PORT_W-1:0] value,
    output logic                              q_push,
    output logic [ENTRY_W-1:0]                q_data,
    input  logic                              q_full
);

    localparam int STEPS  = (VALUE_WIDTH + sbda_pkg::BITS_PER_STEP - 1) / sbda_pkg::BITS_PER_STEP;
    localparam int PAD_W  = STEPS * sbda_pkg::BITS_PER_STEP;
    localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int BCD_W  = NUM_DIGITS * 4;

    typedef enum logic [1:0] {
        IDLE,
        CONVERT,
        DONE
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   neg_reg;
    logic [PAD_W-1:0]       bin_reg;
    logic [BCD_W-1:0]       bcd_reg;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   accept;
    logic [PAD_W-1:0]       bin_next;
    logic [BCD_W-1:0]       bcd_next;
    logic [IDX_W-1:0]       top_idx;

    assign raw    = value[VALUE_WIDTH-1:0];
    assign mag    = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
    assign full   = (state_reg != IDLE);
    assign accept = push && !full;

    always_comb
    begin
        logic [BCD_W-1:0] work;
        logic [PAD_W-1:0] bits;
        work = bcd_reg;
        bits = bin_reg;
        for (int s = 0; s < sbda_pkg::BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (work[d*4 +: 4] >= sbda_pkg::BCD_ADJUST_LIMIT)
                begin
                    work[d*4 +: 4] = work[d*4 +: 4] + sbda_pkg::BCD_ADJUST;
                end
            end
            work = {work[BCD_W-2:0], bits[PAD_W-1]};
            bits = {bits[PAD_W-2:0], 1'b0};
        end
        bcd_next = work;
        bin_next = bits;
    end

    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
            begin
                top_idx = IDX_W'(d);
            end
        end
    end

    assign q_push = (state_reg == DONE) && !q_full;
    assign q_data = {neg_reg, top_idx, bcd_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= CONVERT;
                        cnt_reg   <= '0;
                    end
                end
                CONVERT:
                begin
                    if (cnt_reg == CNT_W'(STEPS - 1))
                    begin
                        state_reg <= DONE;
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                DONE:
                begin
                    if (!q_full)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= raw[VALUE_WIDTH-1];
            bin_reg <= PAD_W'(mag);
            bcd_reg <= '0;
        end
        else if (state_reg == CONVERT)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

endmodule

/* design/sbda_queue.sv */
// Short queue of converted numbers between the front and back ends.
module sbda_queue #(
    parameter int ENTRY_W = 8,
    parameter int DEPTH   = sbda_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [ENTRY_W-1:0] wr_data,
    output logic               q_full,
    input  logic               rd_en,
    output logic [ENTRY_W-1:0] rd_data,
    output logic               q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* design/sbda_back.sv */
// Back end: emits sign and significant digits of one number, one character a cycle on pop.
module sbda_back #(
    parameter int NUM_DIGITS = 20,
    parameter int IDX_W      = 5,
    parameter int ENTRY_W    = 1 + IDX_W + NUM_DIGITS * 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  logic [ENTRY_W-1:0]          q_data,
    output logic                        q_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [sbda_pkg::CHAR_W-1:0] char_code,
    output logic                        last
);

    localparam int BCD_W = NUM_DIGITS * 4;

    logic             active_reg;
    logic             sign_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [BCD_W-1:0] bcd_reg;

    logic             take;
    logic             final_char;
    logic             load;
    logic [3:0]       digit;

    assign final_char = !sign_reg && (idx_reg == '0);
    assign take       = pop && active_reg;
    assign load       = !q_empty && (!active_reg || (take && final_char));
    assign q_pop      = load;

    assign digit     = bcd_reg[idx_reg*4 +: 4];
    assign empty     = !active_reg;
    assign last      = final_char;
    assign char_code = sign_reg ? sbda_pkg::MINUS_CODE
                                : sbda_pkg::DIGIT_BASE + {4'd0, digit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sign_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            sign_reg   <= q_data[ENTRY_W-1];
            idx_reg    <= q_data[BCD_W +: IDX_W];
        end
        else if (take)
        begin
            if (sign_reg)
            begin
                sign_reg <= 1'b0;
            end
            else if (idx_reg == '0)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= q_data[BCD_W-1:0];
        end
    end

endmodule

/* design/signed_binary_to_decimal_ascii_unit.sv */
// Top level of the signed binary to decimal ASCII unit.
//
//  Channel   Handshake          Payload            Meaning
//  request   push / full        value[63:0]        signed integer, low VALUE_WIDTH bits used
//  result    empty / pop        char_code, last    one ASCII character, last marks the end
//
// The front end takes a request, converts its magnitude by four-bit double-dabble steps
// and then hands it to the queue; it takes no new request until that hand-off is done.
// The back end emits one character a cycle while pop is high, up to 20 for one number
// at 64 bits, while the front end converts the next number.
// A stalled result holds the back end; the front end stalls only when the queue is full.
// Reset empties the queue and both ends at once; no clearing pass is needed.
module signed_binary_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [sbda_pkg::VALUE_PORT_W-1:0] value,
    output logic                              empty,
    input  logic                              pop,
    output logic [sbda_pkg::CHAR_W-1:0]       char_code,
    output logic                              last
);

    localparam int NUM_DIGITS = sbda_pkg::digit_count(VALUE_WIDTH);
    localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int ENTRY_W    = 1 + IDX_W + NUM_DIGITS * 4;

    logic               fq_push;
    logic [ENTRY_W-1:0] fq_data;
    logic               fq_full;
    logic               bq_pop;
    logic [ENTRY_W-1:0] bq_data;
    logic               bq_empty;

    sbda_front #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .NUM_DIGITS (NUM_DIGITS),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .value  (value),
        .q_push (fq_push),
        .q_data (fq_data),
        .q_full (fq_full)
    );

    sbda_queue #(
        .ENTRY_W(ENTRY_W),
        .DEPTH  (sbda_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_data),
        .q_full  (fq_full),
        .rd_en   (bq_pop),
        .rd_data (bq_data),
        .q_empty (bq_empty)
    );

    sbda_back #(
        .NUM_DIGITS(NUM_DIGITS),
        .IDX_W     (IDX_W),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (bq_empty),
        .q_data    (bq_data),
        .q_pop     (bq_pop),
        .empty     (empty),
        .pop       (pop),
        .char_code (char_code),
        .last      (last)
    );

    // The front end never offers a converted number to a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) fq_push |-> !fq_full)
        else $error("Converted number pushed into a full queue.");

    // A character taken without the end mark is always followed by another one.
    assert property (@(posedge clk) disable iff (!rst_n) (pop && !empty && !last) |=> !empty)
        else $error("Number text ended without an end mark.");

    // A minus sign is always followed by a digit, never by another sign.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && char_code == sbda_pkg::MINUS_CODE)
        |=> (!empty && char_code != sbda_pkg::MINUS_CODE))
        else $error("Minus sign not followed by a digit.");

endmodule
